>>> rtl/full_linear_convolution_core_assert.svh
// Assertion macros shared by the convolution core RTL.
`ifndef FULL_LINEAR_CONVOLUTION_CORE_ASSERT_SVH
`define FULL_LINEAR_CONVOLUTION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FLCONV_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("convolution core assertion failed");

// Next-cycle implication, disabled during reset.
`define FLCONV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("convolution core assertion failed");

`endif

>>> rtl/flconv_pkg.sv
`timescale 1ns / 1ps
package flconv_pkg;

   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 32;
   localparam int VALUE_W  = 40;
   localparam int CSR_W    = 6;
   localparam int INDEX_W  = 5;
   localparam int CMP_W    = 7;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_HOLD
   } flconv_state_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic final_tap;
   } flconv_issue_type;

   typedef struct packed {
      logic                       shift;
      logic                       clear;
      logic signed [SAMPLE_W-1:0] data;
   } flconv_dly_ctl_type;

endpackage

>>> rtl/flconv_coef_mem.sv
`timescale 1ns / 1ps
module flconv_coef_mem #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [flconv_pkg::INDEX_W-1:0]      wr_index,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]                    rd_addr,
   output logic signed [flconv_pkg::SAMPLE_W-1:0] rd_data
);
   import flconv_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];
   logic [MAX_TAPS-1:0]        vld_ff;
   logic [MAX_TAPS-1:0]        vld_in;
   logic signed [SAMPLE_W-1:0] rd_q_ff;
   logic                       rd_ok_ff;
   logic                       in_range;
   logic [IDX_W-1:0]           wr_addr;

   assign in_range = {{(CMP_W-INDEX_W){1'b0}}, wr_index} < CMP_W'(MAX_TAPS);
   assign wr_addr  = IDX_W'(wr_index);

   always_comb begin
      vld_in = vld_ff;
      if (wr_en && in_range) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         vld_ff   <= vld_in;
         rd_ok_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

endmodule

>>> rtl/flconv_delay_line.sv
`timescale 1ns / 1ps
module flconv_delay_line #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  flconv_pkg::flconv_dly_ctl_type         ctl,
   input  logic [IDX_W-1:0]                       rd_addr,
   output logic signed [flconv_pkg::SAMPLE_W-1:0] rd_data
);
   import flconv_pkg::*;

   logic signed [SAMPLE_W-1:0] line_ff [MAX_TAPS];
   logic signed [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int k = 0; k < MAX_TAPS; k++) begin
            line_ff[k] <= '0;
         end
      end else if (ctl.shift) begin
         for (int k = 1; k < MAX_TAPS; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
         line_ff[0] <= ctl.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= line_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/flconv_mac.sv
`timescale 1ns / 1ps
`include "full_linear_convolution_core_assert.svh"
module flconv_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  flconv_pkg::flconv_issue_type           issue,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] coef,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] samp,
   output logic signed [flconv_pkg::VALUE_W-1:0]  acc,
   output logic                                   done
);
   import flconv_pkg::*;

   flconv_issue_type           s1_ff;
   flconv_issue_type           s2_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [VALUE_W-1:0]  acc_ff;
   logic signed [VALUE_W-1:0]  prod_ext;
   logic                       done_ff;

   assign prod_ext = {{(VALUE_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff   <= '0;
         s2_ff   <= '0;
         done_ff <= 1'b0;
      end else begin
         s1_ff   <= issue;
         s2_ff   <= s1_ff;
         done_ff <= s2_ff.valid && s2_ff.final_tap;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff.valid) begin
         prod_ff <= coef * samp;
      end
      if (s2_ff.valid) begin
         acc_ff <= s2_ff.first ? prod_ext : acc_ff + prod_ext;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

   `FLCONV_ASSERT_NEXT(a_done_single, clock, reset, done_ff, !done_ff)

endmodule

>>> rtl/flconv_ctrl.sv
`timescale 1ns / 1ps
`include "full_linear_convolution_core_assert.svh"
module flconv_ctrl #(
   parameter int MAX_TAPS = 32,
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [flconv_pkg::CSR_W-1:0]           csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [flconv_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                   rsp_last,
   output logic                                   coef_wr,
   output logic [IDX_W-1:0]                       rd_idx,
   output flconv_pkg::flconv_issue_type           issue,
   output flconv_pkg::flconv_dly_ctl_type         dly_ctl,
   input  logic signed [flconv_pkg::VALUE_W-1:0]  mac_acc,
   input  logic                                   mac_done
);
   import flconv_pkg::*;

   flconv_state_type           state_ff, state_in;
   logic [CSR_W-1:0]           tap_count_ff;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]           last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]           rem_ff, rem_in;
   logic                       fin_ff, fin_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff;
   logic                       rsp_last_ff;
   logic [CMP_W-1:0]           cnt_ext;
   logic [CMP_W-1:0]           taps_sel;
   logic [CMP_W-1:0]           taps_m1;
   logic                       sample_acc;
   logic                       out_free;
   logic                       emit;
   logic                       final_out;

   assign cnt_ext = {{(CMP_W-CSR_W){1'b0}}, tap_count_ff};

   always_comb begin
      if (cnt_ext == '0) begin
         taps_sel = CMP_W'(1);
      end else if (cnt_ext > CMP_W'(MAX_TAPS)) begin
         taps_sel = CMP_W'(MAX_TAPS);
      end else begin
         taps_sel = cnt_ext;
      end
   end

   assign taps_m1   = taps_sel - CMP_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign final_out = fin_ff && (rem_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_acc) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = (rem_ff != '0) ? ST_ISSUE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      sample_acc      = 1'b0;
      coef_wr         = 1'b0;
      emit            = 1'b0;
      issue           = '0;
      dly_ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            sample_acc   = req_valid && (req_command == CMD_SAMPLE);
            coef_wr      = req_valid && (req_command == CMD_LOAD);
            dly_ctl.shift = sample_acc;
            dly_ctl.data  = req_sample;
         end
         ST_ISSUE: begin
            issue.valid     = 1'b1;
            issue.first     = (idx_ff == '0);
            issue.final_tap = (idx_ff == last_idx_ff);
         end
         ST_DRAIN: begin
         end
         ST_HOLD: begin
            emit          = out_free;
            dly_ctl.shift = out_free && (rem_ff != '0);
            dly_ctl.clear = out_free && final_out;
         end
         default: begin
         end
      endcase
   end

   assign rd_idx = idx_ff;

   always_comb begin
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      rem_in       = rem_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (sample_acc) begin
         idx_in      = '0;
         last_idx_in = IDX_W'(taps_m1);
         rem_in      = req_last_sample ? IDX_W'(taps_m1) : '0;
         fin_in      = req_last_sample;
      end else if (issue.valid && !issue.final_tap) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (emit) begin
         idx_in       = '0;
         rsp_valid_in = 1'b1;
         if (rem_ff != '0) begin
            rem_in = rem_ff - IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= CSR_W'(1);
         idx_ff       <= '0;
         last_idx_ff  <= '0;
         rem_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_idx_ff  <= last_idx_in;
         rem_ff       <= rem_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            tap_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= mac_acc;
         rsp_last_ff  <= final_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

   `FLCONV_ASSERT_IMPL(a_done_in_drain, clock, reset, mac_done, state_ff == ST_DRAIN)
   `FLCONV_ASSERT_IMPL(a_idle_no_flush, clock, reset, req_ready, rem_ff == '0)
   `FLCONV_ASSERT_IMPL(a_idx_bound, clock, reset, issue.valid, idx_ff <= last_idx_ff)

endmodule

>>> rtl/full_linear_convolution_core.sv
`timescale 1ns / 1ps
// Full linear convolution of a 16-bit sample stream with a loaded FIR filter of up to
// MAX_TAPS Q1.15 coefficients, giving exact 40-bit sums with 15 fraction bits. A load
// transaction (command 0) writes one coefficient and returns nothing. A sample transaction
// (command 1) returns one output; with last_sample set it is followed by tap_count - 1
// flush outputs, tap_count being clamped to 1..MAX_TAPS, the final one flagged by rsp_last,
// after which the delay line is clear. The outputs are computed by the single
// multiply-accumulate unit, which walks one tap per cycle behind the registered read of
// the coefficient memory. The request side is not ready while an output is computed, but
// a finished output may wait on the response side while the next transaction is taken.
// Coefficients reset to zero; tap_count resets to 1. It is to be written through
// csr_write_enable only while the core is idle; the core itself does not enforce this.
module full_linear_convolution_core #(
   parameter int MAX_TAPS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [flconv_pkg::CSR_W-1:0]           csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [flconv_pkg::INDEX_W-1:0]         req_tap_index,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] req_coefficient,
   input  logic signed [flconv_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                   req_last_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [flconv_pkg::VALUE_W-1:0]  rsp_value,
   output logic                                   rsp_last
);
   import flconv_pkg::*;

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   logic                       coef_wr;
   logic [IDX_W-1:0]           rd_idx;
   flconv_issue_type           issue;
   flconv_dly_ctl_type         dly_ctl;
   logic signed [SAMPLE_W-1:0] coef_q;
   logic signed [SAMPLE_W-1:0] samp_q;
   logic signed [VALUE_W-1:0]  mac_acc;
   logic                       mac_done;

   flconv_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_sample       (req_sample),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last),
      .coef_wr          (coef_wr),
      .rd_idx           (rd_idx),
      .issue            (issue),
      .dly_ctl          (dly_ctl),
      .mac_acc          (mac_acc),
      .mac_done         (mac_done)
   );

   flconv_coef_mem #(.MAX_TAPS(MAX_TAPS)) u_coef_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (coef_wr),
      .wr_index (req_tap_index),
      .wr_data  (req_coefficient),
      .rd_addr  (rd_idx),
      .rd_data  (coef_q)
   );

   flconv_delay_line #(.MAX_TAPS(MAX_TAPS)) u_delay_line (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dly_ctl),
      .rd_addr (rd_idx),
      .rd_data (samp_q)
   );

   flconv_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .coef  (coef_q),
      .samp  (samp_q),
      .acc   (mac_acc),
      .done  (mac_done)
   );

endmodule
